@@ rtl/core/aes_pkg.sv @@
// Shared types, constants and byte-level functions of the AES block cipher.
// Used by aes_ctrl, aes_dp and aes_block_cipher_top; depends on nothing else.
package aes_pkg;

  localparam int BlkW  = 128;
  localparam int WordW = 32;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY_SIZE   = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd3;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd4;

  // The one key size code that has no meaning.
  localparam logic [1:0] KS_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    RK_FIRST,
    RK_MID,
    RK_LAST
  } rnd_kind_t;

  typedef struct packed {
    logic      load_in;
    logic      exp_step;
    logic [5:0] exp_idx;
    logic      sched_set;
    logic      rd_en;
    logic [3:0] rd_row;
    logic      rnd_en;
    rnd_kind_t rnd_kind;
    logic      out_load;
  } aes_cmd_t;

  typedef struct packed {
    logic       sched_valid;
    logic       dec;
    logic [1:0] key_size;
    logic       out_free;
  } aes_sts_t;

  localparam logic [7:0] FWD_SBOX [0:255] = '{
    'h63,'h7c,'h77,'h7b,'hf2,'h6b,'h6f,'hc5,'h30,'h01,'h67,'h2b,'hfe,'hd7,'hab,'h76,
    'hca,'h82,'hc9,'h7d,'hfa,'h59,'h47,'hf0,'had,'hd4,'ha2,'haf,'h9c,'ha4,'h72,'hc0,
    'hb7,'hfd,'h93,'h26,'h36,'h3f,'hf7,'hcc,'h34,'ha5,'he5,'hf1,'h71,'hd8,'h31,'h15,
    'h04,'hc7,'h23,'hc3,'h18,'h96,'h05,'h9a,'h07,'h12,'h80,'he2,'heb,'h27,'hb2,'h75,
    'h09,'h83,'h2c,'h1a,'h1b,'h6e,'h5a,'ha0,'h52,'h3b,'hd6,'hb3,'h29,'he3,'h2f,'h84,
    'h53,'hd1,'h00,'hed,'h20,'hfc,'hb1,'h5b,'h6a,'hcb,'hbe,'h39,'h4a,'h4c,'h58,'hcf,
    'hd0,'hef,'haa,'hfb,'h43,'h4d,'h33,'h85,'h45,'hf9,'h02,'h7f,'h50,'h3c,'h9f,'ha8,
    'h51,'ha3,'h40,'h8f,'h92,'h9d,'h38,'hf5,'hbc,'hb6,'hda,'h21,'h10,'hff,'hf3,'hd2,
    'hcd,'h0c,'h13,'hec,'h5f,'h97,'h44,'h17,'hc4,'ha7,'h7e,'h3d,'h64,'h5d,'h19,'h73,
    'h60,'h81,'h4f,'hdc,'h22,'h2a,'h90,'h88,'h46,'hee,'hb8,'h14,'hde,'h5e,'h0b,'hdb,
    'he0,'h32,'h3a,'h0a,'h49,'h06,'h24,'h5c,'hc2,'hd3,'hac,'h62,'h91,'h95,'he4,'h79,
    'he7,'hc8,'h37,'h6d,'h8d,'hd5,'h4e,'ha9,'h6c,'h56,'hf4,'hea,'h65,'h7a,'hae,'h08,
    'hba,'h78,'h25,'h2e,'h1c,'ha6,'hb4,'hc6,'he8,'hdd,'h74,'h1f,'h4b,'hbd,'h8b,'h8a,
    'h70,'h3e,'hb5,'h66,'h48,'h03,'hf6,'h0e,'h61,'h35,'h57,'hb9,'h86,'hc1,'h1d,'h9e,
    'he1,'hf8,'h98,'h11,'h69,'hd9,'h8e,'h94,'h9b,'h1e,'h87,'he9,'hce,'h55,'h28,'hdf,
    'h8c,'ha1,'h89,'h0d,'hbf,'he6,'h42,'h68,'h41,'h99,'h2d,'h0f,'hb0,'h54,'hbb,'h16};

  localparam logic [7:0] DEC_SBOX [0:255] = '{
    'h52,'h09,'h6a,'hd5,'h30,'h36,'ha5,'h38,'hbf,'h40,'ha3,'h9e,'h81,'hf3,'hd7,'hfb,
    'h7c,'he3,'h39,'h82,'h9b,'h2f,'hff,'h87,'h34,'h8e,'h43,'h44,'hc4,'hde,'he9,'hcb,
    'h54,'h7b,'h94,'h32,'ha6,'hc2,'h23,'h3d,'hee,'h4c,'h95,'h0b,'h42,'hfa,'hc3,'h4e,
    'h08,'h2e,'ha1,'h66,'h28,'hd9,'h24,'hb2,'h76,'h5b,'ha2,'h49,'h6d,'h8b,'hd1,'h25,
    'h72,'hf8,'hf6,'h64,'h86,'h68,'h98,'h16,'hd4,'ha4,'h5c,'hcc,'h5d,'h65,'hb6,'h92,
    'h6c,'h70,'h48,'h50,'hfd,'hed,'hb9,'hda,'h5e,'h15,'h46,'h57,'ha7,'h8d,'h9d,'h84,
    'h90,'hd8,'hab,'h00,'h8c,'hbc,'hd3,'h0a,'hf7,'he4,'h58,'h05,'hb8,'hb3,'h45,'h06,
    'hd0,'h2c,'h1e,'h8f,'hca,'h3f,'h0f,'h02,'hc1,'haf,'hbd,'h03,'h01,'h13,'h8a,'h6b,
    'h3a,'h91,'h11,'h41,'h4f,'h67,'hdc,'hea,'h97,'hf2,'hcf,'hce,'hf0,'hb4,'he6,'h73,
    'h96,'hac,'h74,'h22,'he7,'had,'h35,'h85,'he2,'hf9,'h37,'he8,'h1c,'h75,'hdf,'h6e,
    'h47,'hf1,'h1a,'h71,'h1d,'h29,'hc5,'h89,'h6f,'hb7,'h62,'h0e,'haa,'h18,'hbe,'h1b,
    'hfc,'h56,'h3e,'h4b,'hc6,'hd2,'h79,'h20,'h9a,'hdb,'hc0,'hfe,'h78,'hcd,'h5a,'hf4,
    'h1f,'hdd,'ha8,'h33,'h88,'h07,'hc7,'h31,'hb1,'h12,'h10,'h59,'h27,'h80,'hec,'h5f,
    'h60,'h51,'h7f,'ha9,'h19,'hb5,'h4a,'h0d,'h2d,'he5,'h7a,'h9f,'h93,'hc9,'h9c,'hef,
    'ha0,'he0,'h3b,'h4d,'hae,'h2a,'hf5,'hb0,'hc8,'heb,'hbb,'h3c,'h83,'h53,'h99,'h61,
    'h17,'h2b,'h04,'h7e,'hba,'h77,'hd6,'h26,'he1,'h69,'h14,'h63,'h55,'h21,'h0c,'h7d};

  function automatic logic [7:0] xt(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // SubBytes followed by ShiftRows; byte n of the block sits at [127-8n -: 8].
  function automatic logic [127:0] sub_shift_fwd(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = FWD_SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] sub_shift_inv(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = DEC_SBOX[s[127-8*(4*((c-r+4)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] x);
    return xt(xt(xt(x))) ^ x;
  endfunction

  function automatic logic [7:0] mulb(input logic [7:0] x);
    return xt(xt(xt(x))) ^ xt(x) ^ x;
  endfunction

  function automatic logic [7:0] muld(input logic [7:0] x);
    return xt(xt(xt(x))) ^ xt(xt(x)) ^ x;
  endfunction

  function automatic logic [7:0] mule(input logic [7:0] x);
    return xt(xt(xt(x))) ^ xt(xt(x)) ^ xt(x);
  endfunction

  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = mule(a0) ^ mulb(a1) ^ muld(a2) ^ mul9(a3);
      t[119-32*c -: 8] = mul9(a0) ^ mule(a1) ^ mulb(a2) ^ muld(a3);
      t[111-32*c -: 8] = muld(a0) ^ mul9(a1) ^ mule(a2) ^ mulb(a3);
      t[103-32*c -: 8] = mulb(a0) ^ muld(a1) ^ mul9(a2) ^ mule(a3);
    end
    return t;
  endfunction

endpackage

@@ rtl/core/aes_ctrl.sv @@
// Sequencer of the AES block cipher: key expansion, round stepping and result hand-off.
// Depends on aes_pkg; drives the command struct of aes_dp and reads its status.
module aes_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  aes_pkg::aes_sts_t sts,
  output aes_pkg::aes_cmd_t cmd
);
  import aes_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PREP,
    ST_ROUND,
    ST_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [3:0] nr;
  logic [5:0] last_idx;

  assign nr       = {1'b0, sts.key_size, 1'b0} + 4'd10;
  assign last_idx = {nr, 2'b11};
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rnd_nxt   = rnd_r;
    cmd       = '0;
    cmd.exp_idx  = idx_r;
    cmd.rnd_kind = RK_MID;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          idx_nxt     = '0;
          state_nxt   = sts.sched_valid ? ST_PREP : ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        idx_nxt      = idx_r + 6'd1;
        if (idx_r == last_idx) begin
          cmd.sched_set = 1'b1;
          state_nxt     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_row = sts.dec ? nr : 4'd0;
        rnd_nxt    = '0;
        state_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.rnd_en = 1'b1;
        if (rnd_r == 4'd0) begin
          cmd.rnd_kind = RK_FIRST;
        end else if (rnd_r == nr) begin
          cmd.rnd_kind = RK_LAST;
        end
        if (rnd_r != nr) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_row = sts.dec ? (nr - rnd_r - 4'd1) : (rnd_r + 4'd1);
          rnd_nxt    = rnd_r + 4'd1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  a_round_needs_schedule: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> sts.sched_valid)
    else $error("round started without an expanded key schedule");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an unaccepted result");

  a_round_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r <= nr))
    else $error("round counter ran past the last round");

endmodule

@@ rtl/core/aes_dp.sv @@
// Datapath of the AES block cipher: key registers, schedule expansion, round key
// banks, the round function and the result register. Depends on aes_pkg.
module aes_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              in_op,
  input  logic [63:0]       in_block_hi,
  input  logic [63:0]       in_block_lo,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [63:0]       out_result_hi,
  output logic [63:0]       out_result_lo,
  input  aes_pkg::aes_cmd_t cmd,
  output aes_pkg::aes_sts_t sts
);
  import aes_pkg::*;

  logic [1:0]   key_size_r;
  logic [63:0]  key_w_r [4];
  logic         sched_valid_r;
  logic         op_r;
  logic [127:0] blk_r, blk_nxt;
  logic [127:0] res_r;
  logic         out_valid_r;
  logic [31:0]  win_r [8];
  logic [2:0]   j_r;
  logic [7:0]   rc_r;
  logic [31:0]  rk_r [4];

  logic [3:0]   nk;
  logic [2:0]   nk_m1;
  logic [2:0]   cur_j;
  logic [7:0]   cur_rc;
  logic [31:0]  far_w;
  logic [31:0]  key_half;
  logic [31:0]  tmp_w;
  logic [31:0]  new_w;
  logic         is_key;
  logic [127:0] rkey;

  assign nk    = {1'b0, key_size_r, 1'b0} + 4'd4;
  assign nk_m1 = nk[2:0] - 3'd1;
  assign cur_j  = (cmd.exp_idx == 6'd0) ? 3'd0 : j_r;
  assign cur_rc = (cmd.exp_idx == 6'd0) ? 8'h01 : rc_r;
  assign is_key = (cmd.exp_idx < {2'b00, nk});
  assign far_w  = win_r[nk_m1];
  assign key_half = cmd.exp_idx[0] ? key_w_r[cmd.exp_idx[2:1]][31:0]
                                   : key_w_r[cmd.exp_idx[2:1]][63:32];

  always_comb begin
    tmp_w = win_r[0];
    if (cur_j == 3'd0) begin
      tmp_w = sub_word({win_r[0][23:0], win_r[0][31:24]}) ^ {cur_rc, 24'h0};
    end else if ((nk == 4'd8) && (cur_j == 3'd4)) begin
      tmp_w = sub_word(win_r[0]);
    end
    new_w = is_key ? key_half : (far_w ^ tmp_w);
  end

  // Round key words: word i goes to bank i mod 4, row i / 4.
  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [31:0] bank_mem [0:14];
    always_ff @(posedge clk) begin
      if (cmd.exp_step && (cmd.exp_idx[1:0] == 2'(gb))) begin
        bank_mem[cmd.exp_idx[5:2]] <= new_w;
      end
      if (cmd.rd_en) begin
        rk_r[gb] <= bank_mem[cmd.rd_row];
      end
    end
  end

  assign rkey = {rk_r[0], rk_r[1], rk_r[2], rk_r[3]};

  always_comb begin
    blk_nxt = blk_r;
    case (cmd.rnd_kind)
      RK_FIRST: blk_nxt = blk_r ^ rkey;
      RK_MID:   blk_nxt = op_r ? mix_inv(sub_shift_inv(blk_r) ^ rkey)
                               : (mix_fwd(sub_shift_fwd(blk_r)) ^ rkey);
      RK_LAST:  blk_nxt = op_r ? (sub_shift_inv(blk_r) ^ rkey)
                               : (sub_shift_fwd(blk_r) ^ rkey);
      default:  blk_nxt = blk_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      blk_r <= {in_block_hi, in_block_lo};
      op_r  <= in_op;
    end else if (cmd.rnd_en) begin
      blk_r <= blk_nxt;
    end
    if (cmd.exp_step) begin
      win_r[0] <= new_w;
      for (int k = 1; k < 8; k++) begin
        win_r[k] <= win_r[k-1];
      end
      j_r  <= (cur_j == nk_m1) ? 3'd0 : (cur_j + 3'd1);
      rc_r <= (!is_key && (cur_j == 3'd0)) ? xt(cur_rc) : cur_rc;
    end
    if (cmd.out_load) begin
      res_r <= blk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r    <= '0;
      key_w_r       <= '{default: '0};
      sched_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.sched_set) begin
        sched_valid_r <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_SIZE: begin
            if (cfg_data[1:0] != KS_RESERVED) begin
              key_size_r <= cfg_data[1:0];
            end
            sched_valid_r <= 1'b0;
          end
          CFG_KEY_WORD_0: begin
            key_w_r[0]    <= cfg_data;
            sched_valid_r <= 1'b0;
          end
          CFG_KEY_WORD_1: begin
            key_w_r[1]    <= cfg_data;
            sched_valid_r <= 1'b0;
          end
          CFG_KEY_WORD_2: begin
            key_w_r[2]    <= cfg_data;
            sched_valid_r <= 1'b0;
          end
          CFG_KEY_WORD_3: begin
            key_w_r[3]    <= cfg_data;
            sched_valid_r <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result_hi = res_r[127:64];
  assign out_result_lo = res_r[63:0];

  assign sts.sched_valid = sched_valid_r;
  assign sts.dec         = op_r;
  assign sts.key_size    = key_size_r;
  assign sts.out_free    = !out_valid_r || !out_stall;

endmodule

@@ rtl/core/aes_block_cipher_top.sv @@
// AES block cipher, 128/192/256-bit keys (Nr = 10, 12, 14), one block at a time.
// A block goes through the rounds and then into the result register, which raises out_valid;
// key expansion (one schedule word per cycle) runs first after reset or a key or size write.
// The single shared round unit takes a new block only once the last result is in that register.
// Reset (rst_n low, synchronous) clears the key registers, marks the schedule stale
// and clears out_valid; the result register and the round key banks are left as they are.
module aes_block_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo
);
  import aes_pkg::*;

  // The controller steps the key expansion and the rounds; the datapath holds
  // every register that carries key or block data.
  aes_cmd_t cmd;
  aes_sts_t sts;

  // A request is taken only while the sequencer is idle, but a finished result
  // may still wait in the output register meanwhile.
  aes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  aes_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (in_op),
    .in_block_hi   (in_block_hi),
    .in_block_lo   (in_block_lo),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_result_hi (out_result_hi),
    .out_result_lo (out_result_lo),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
